// ===== rtl/core/arp_table_flood_detector_defines.svh =====
// Assertion macros for the ARP table flood detector.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ARP_TABLE_FLOOD_DETECTOR_DEFINES_SVH
`define ARP_TABLE_FLOOD_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("afd check failed");

// The consequent must hold in the cycle after the antecedent.
`define AFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("afd check failed");

`endif

// ===== rtl/core/afd_pkg.sv =====
// Shared types and constants of the ARP table flood detector.
// No dependencies; used by every module of the block.
package afd_pkg;

  localparam int unsigned AFD_TABLE_DEPTH = 64;
  localparam int unsigned AFD_ADDR_W      = 3;
  localparam logic [15:0] AFD_MIN_GAP_RST = 16'd10;
  localparam logic [15:0] OP_REQUEST      = 16'd1;
  localparam logic [15:0] OP_REPLY        = 16'd2;
  localparam logic        REG_MIN_GAP     = 1'b0;

  typedef enum logic [1:0] {
    PHASE_INIT  = 2'd0,
    PHASE_REQ   = 2'd1,
    PHASE_REPLY = 2'd2
  } afd_phase_e;

  typedef enum logic [1:0] {
    EV_OK    = 2'd0,
    EV_FLOOD = 2'd1,
    EV_FULL  = 2'd2
  } afd_event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } afd_state_e;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [47:0] peer_mac;
    logic [31:0] own_ip;
    logic [31:0] peer_ip;
    afd_phase_e  phase;
    logic        resolved;
    logic [31:0] last_seen_ms;
  } afd_row_t;

endpackage

// ===== rtl/core/arp_table_flood_detector.sv =====
// On a miss the sequencer scans every filled row before it updates the table; on a hit
// in slot k it stops after that row. The result strobe is registered from the update state.
// A new frame is taken only in idle, so frames are handled one at a time; the single read
// port of the table memory gives one row compared per cycle. The receiver cannot stall.
// Reset empties the table at once through the fill count; min_gap_ms returns to 10.
`include "arp_table_flood_detector_defines.svh"

module arp_table_flood_detector #(
  parameter int unsigned TABLE_DEPTH = afd_pkg::AFD_TABLE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [47:0]                    sender_hw_i,
  input  logic [47:0]                    target_hw_i,
  input  logic [31:0]                    sender_ip_i,
  input  logic [31:0]                    target_ip_i,
  input  logic [15:0]                    opcode_i,
  input  logic [31:0]                    now_ms_i,
  output logic                           done_o,
  output logic [1:0]                     event_res_o,
  output logic [5:0]                     entry_index_o,
  output logic                           entry_resolved_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [afd_pkg::AFD_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import afd_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  logic [15:0]     min_gap;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  afd_row_t        mem_wdata, mem_rdata;

  afd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .min_gap_o (min_gap)
  );

  afd_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  afd_ctrl #(
    .DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .sender_hw_i      (sender_hw_i),
    .target_hw_i      (target_hw_i),
    .sender_ip_i      (sender_ip_i),
    .target_ip_i      (target_ip_i),
    .opcode_i         (opcode_i),
    .now_ms_i         (now_ms_i),
    .min_gap_i        (min_gap),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata),
    .done_o           (done_o),
    .event_res_o      (event_res_o),
    .entry_index_o    (entry_index_o),
    .entry_resolved_o (entry_resolved_o)
  );

  // A transfer starts a scan, and its result cannot appear in the very next cycle.
  `AFD_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o && !done_o)
  // The result is presented only after the sequencer has gone back to idle.
  `AFD_ASSERT_NOW(a_done_idle, done_o, !busy_o)
  // A full table reports slot zero, unresolved.
  `AFD_ASSERT_NOW(a_full_zero, done_o && (event_res_o == EV_FULL),
                  (entry_index_o == 6'd0) && !entry_resolved_o)
  // A new entry is never resolved, so only a hit can give a resolved result.
  `AFD_ASSERT_NOW(a_resolved_ok, done_o && entry_resolved_o, event_res_o != EV_FULL)

endmodule

// ===== rtl/core/afd_mem.sv =====
// Table storage: one write port, one read port, registered read data.
// Depends on afd_pkg for the row type.
module afd_mem #(
  parameter int unsigned DEPTH = afd_pkg::AFD_TABLE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  afd_pkg::afd_row_t        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output afd_pkg::afd_row_t        rdata_o
);
  import afd_pkg::*;

  afd_row_t mem_q [DEPTH];
  afd_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/afd_cfg.sv =====
// Configuration register file behind an APB-style port.
// Depends on afd_pkg for the register index and reset value.
module afd_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [afd_pkg::AFD_ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [15:0]                  min_gap_o
);
  import afd_pkg::*;

  logic [15:0] min_gap_q;
  logic        wr_en;

  // Registers are word aligned; the word index is the bit above the byte offset.
  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_MIN_GAP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q <= AFD_MIN_GAP_RST;
    end else if (wr_en) begin
      min_gap_q <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_GAP: prdata = {16'd0, min_gap_q};
      default:     prdata = 32'd0;
    endcase
  end

  assign pready    = 1'b1;
  assign min_gap_o = min_gap_q;

endmodule

// ===== rtl/core/afd_ctrl.sv =====
// Sequencer: scans the table memory for a matching MAC, then inserts or
// updates one row, unless the table is full, and produces the result. Depends on afd_pkg.
module afd_ctrl #(
  parameter int unsigned DEPTH = afd_pkg::AFD_TABLE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [47:0]              sender_hw_i,
  input  logic [47:0]              target_hw_i,
  input  logic [31:0]              sender_ip_i,
  input  logic [31:0]              target_ip_i,
  input  logic [15:0]              opcode_i,
  input  logic [31:0]              now_ms_i,
  input  logic [15:0]              min_gap_i,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output afd_pkg::afd_row_t        mem_wdata_o,
  output logic                     mem_re_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o,
  input  afd_pkg::afd_row_t        mem_rdata_i,
  output logic                     done_o,
  output logic [1:0]               event_res_o,
  output logic [5:0]               entry_index_o,
  output logic                     entry_resolved_o
);
  import afd_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  afd_state_e      state_q, state_d;
  logic [CntW-1:0] scan_addr_q, fill_q;
  logic [IdxW-1:0] cmp_addr_q, hit_idx_q;
  logic            cmp_valid_q, hit_q;
  afd_row_t        hold_q;
  logic [47:0]     smac_q, tmac_q;
  logic [31:0]     sip_q, tip_q, now_q;
  logic [15:0]     op_q;
  logic            done_q, resolved_q;
  afd_event_e      event_q;
  logic [5:0]      index_q;

  logic            accept, issue, match, capture, full, insert;
  afd_row_t        new_row;
  afd_event_e      event_d;
  logic [IdxW-1:0] slot;
  logic [IdxW+5:0] slot_ext;
  logic [31:0]     elapsed;

  assign accept = (state_q == ST_IDLE) && start_i;
  // A row is only compared when its address lies below the fill count, so
  // unwritten rows never take part.
  assign issue  = (state_q == ST_SCAN) && (scan_addr_q < fill_q) && !match;
  assign match  = (state_q == ST_SCAN) && cmp_valid_q &&
                  ((mem_rdata_i.own_mac == smac_q) || (mem_rdata_i.own_mac == tmac_q));
  assign full   = !hit_q && (fill_q == CntW'(DEPTH));
  assign insert = (state_q == ST_UPDATE) && !hit_q && !full;
  assign slot   = hit_q ? hit_idx_q : fill_q[IdxW-1:0];
  assign slot_ext = {6'd0, slot};
  assign elapsed  = now_q - hold_q.last_seen_ms;

  always_comb begin
    state_d = state_q;
    capture = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          capture = 1'b1;
          state_d = ST_UPDATE;
        end else if (!issue && !cmp_valid_q) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (hit_q) begin
      new_row              = hold_q;
      new_row.last_seen_ms = now_q;
      if (op_q == OP_REPLY) begin
        new_row.peer_mac = smac_q;
        new_row.peer_ip  = sip_q;
        new_row.phase    = PHASE_REPLY;
        new_row.resolved = 1'b1;
      end
      event_d = (elapsed < {16'd0, min_gap_i}) ? EV_FLOOD : EV_OK;
    end else begin
      new_row.own_mac      = smac_q;
      new_row.peer_mac     = tmac_q;
      new_row.own_ip       = sip_q;
      new_row.peer_ip      = tip_q;
      new_row.phase        = (op_q == OP_REQUEST) ? PHASE_REQ : PHASE_INIT;
      new_row.resolved     = 1'b0;
      new_row.last_seen_ms = now_q;
      event_d              = full ? EV_FULL : EV_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_addr_q <= '0;
      cmp_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      fill_q      <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_valid_q <= issue;
      done_q      <= (state_q == ST_UPDATE);
      if (accept) begin
        scan_addr_q <= '0;
        hit_q       <= 1'b0;
      end else if (issue) begin
        scan_addr_q <= scan_addr_q + 1'b1;
      end
      if (capture) begin
        hit_q <= 1'b1;
      end
      if (insert) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smac_q <= sender_hw_i;
      tmac_q <= target_hw_i;
      sip_q  <= sender_ip_i;
      tip_q  <= target_ip_i;
      op_q   <= opcode_i;
      now_q  <= now_ms_i;
    end
    if (issue) begin
      cmp_addr_q <= scan_addr_q[IdxW-1:0];
    end
    if (capture) begin
      hold_q    <= mem_rdata_i;
      hit_idx_q <= cmp_addr_q;
    end
    if (state_q == ST_UPDATE) begin
      event_q    <= event_d;
      index_q    <= full ? 6'd0 : slot_ext[5:0];
      resolved_q <= hit_q && new_row.resolved;
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign mem_re_o         = issue;
  assign mem_raddr_o      = scan_addr_q[IdxW-1:0];
  assign mem_we_o         = (state_q == ST_UPDATE) && !full;
  assign mem_waddr_o      = slot;
  assign mem_wdata_o      = new_row;
  assign done_o           = done_q;
  assign event_res_o      = event_q;
  assign entry_index_o    = index_q;
  assign entry_resolved_o = resolved_q;

endmodule
